@@ rtl/mte_pkg.sv @@
package mte_pkg;

   localparam int unsigned VLQ_GROUPS_DEFAULT = 4;
   localparam int unsigned VLQ_BYTES_MAX = 4;
   localparam int unsigned FIELD_WIDTH = 28;
   localparam int unsigned RUN_MAX = 10;
   localparam int unsigned RUN_COUNT_WIDTH = $clog2(RUN_MAX + 1);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_FILL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_META    = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   localparam logic [2:0] MIDI_PROGRAM       = 3'd5;
   localparam logic [2:0] MIDI_CHAN_PRESSURE = 3'd6;

   localparam logic [7:0] META_PREFIX = 8'hff;
   localparam logic [7:0] RS_CLEARED  = 8'h00;

   typedef logic [RUN_COUNT_WIDTH-1:0] run_count_type;

   typedef struct packed {
      logic [VLQ_BYTES_MAX-1:0][7:0] bytes;
      logic [2:0]                    count;
   } vlq_type;

   // One encoded event run, bytes in the order they leave the block.
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      run_count_type           count;
   } run_type;

   function automatic logic [7:0] status_base(input logic [2:0] kind);
      logic [7:0] base;
      case (kind)
         3'd0:    base = 8'h80;
         3'd1:    base = 8'h90;
         3'd2:    base = 8'ha0;
         3'd3:    base = 8'hb0;
         3'd4:    base = 8'hb0;
         3'd5:    base = 8'hc0;
         3'd6:    base = 8'hd0;
         3'd7:    base = 8'he0;
         default: base = 8'h80;
      endcase
      return base;
   endfunction

   // Big-endian VLQ, leading zero groups dropped, saturating when the value
   // does not fit in groups_max groups.
   function automatic vlq_type vlq_encode(input logic [FIELD_WIDTH-1:0] value,
                                          input int unsigned groups_max);
      vlq_type                r;
      logic [FIELD_WIDTH-1:0] v;
      logic [2:0]             n;
      logic [1:0]             sel;
      v = value;
      if (groups_max < VLQ_BYTES_MAX && (value >> (7 * groups_max)) != '0) begin
         v = FIELD_WIDTH'((64'd1 << (7 * groups_max)) - 64'd1);
      end
      n = 3'd1;
      for (int g = 1; g < VLQ_BYTES_MAX; g++) begin
         if (g < groups_max && (v >> (7 * g)) != '0) begin
            n = 3'(g + 1);
         end
      end
      r.bytes = '0;
      r.count = n;
      for (int i = 0; i < VLQ_BYTES_MAX; i++) begin
         sel = 2'(n - 3'd1 - 3'(i));
         if (3'(i) < n) begin
            r.bytes[i] = {(3'(i) != (n - 3'd1)), 7'(v >> (7 * sel))};
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/mte_req_if.sv @@
interface mte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [27:0] tick_delta;
   logic [2:0]  midi_kind;
   logic [3:0]  channel;
   logic [6:0]  data_first;
   logic [6:0]  data_second;
   logic [7:0]  meta_kind;
   logic [27:0] meta_length;
   logic [7:0]  payload_byte;

   modport source(output valid, item_kind, tick_delta, midi_kind, channel, data_first,
                  data_second, meta_kind, meta_length, payload_byte,
                  input ready);
   modport sink(input valid, item_kind, tick_delta, midi_kind, channel, data_first,
                data_second, meta_kind, meta_length, payload_byte,
                output ready);
endinterface

@@ rtl/mte_rsp_if.sv @@
interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source(output valid, out_byte, last, input ready);
   modport sink(input valid, out_byte, last, output ready);
endinterface

@@ rtl/midi_track_event_encoder.sv @@
// Encodes MIDI file track events into a byte stream, one byte per transfer on the
// response channel, with last marking the final byte of each input item's run. A
// channel event comes out as two to seven bytes (delta time VLQ of one to
// four bytes, the status byte unless it matches the running status, one or two data
// bytes), a meta header as four to ten, a payload byte as one; an item of kind 3 is taken
// and dropped. The output register, which sends one byte per cycle while the response
// channel is ready, sets the rate: the bytes of a run leave back to back and the next run
// follows directly. The front encodes each accepted item in its accepting cycle into a
// two-entry queue, so up to two runs can be taken while the output is stalled.
module midi_track_event_encoder #(
   parameter int unsigned VLQ_GROUPS = mte_pkg::VLQ_GROUPS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mte_req_if.sink   req_chan,
   mte_rsp_if.source rsp_chan
);
   import mte_pkg::*;

   logic    push;
   run_type push_run;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   run_type head_run;

   mte_front #(
      .VLQ_GROUPS(VLQ_GROUPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_run   (push_run)
   );

   mte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   mte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ rtl/mte_front.sv @@
module mte_front #(
   parameter int unsigned VLQ_GROUPS = mte_pkg::VLQ_GROUPS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   mte_req_if.sink          req_chan,
   input  logic             queue_full,
   output logic             push,
   output mte_pkg::run_type push_run
);
   import mte_pkg::*;

   logic [7:0]    running_status_ff;
   logic [7:0]    running_status_in;
   vlq_type       delta_vlq;
   vlq_type       length_vlq;
   logic [7:0]    status;
   logic          emit_status;
   logic          two_data;
   logic          accept;
   run_count_type pos;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign push = accept && (req_chan.item_kind == KIND_CHANNEL ||
                            req_chan.item_kind == KIND_META ||
                            req_chan.item_kind == KIND_PAYLOAD);

   always_comb begin
      delta_vlq   = vlq_encode(req_chan.tick_delta, VLQ_GROUPS);
      length_vlq  = vlq_encode(req_chan.meta_length, VLQ_GROUPS);
      status      = status_base(req_chan.midi_kind) | {4'h0, req_chan.channel};
      emit_status = (status != running_status_ff);
      two_data    = (req_chan.midi_kind != MIDI_PROGRAM) &&
                    (req_chan.midi_kind != MIDI_CHAN_PRESSURE);
      push_run    = '0;
      pos         = '0;
      case (req_chan.item_kind)
         KIND_CHANNEL: begin
            for (int i = 0; i < VLQ_BYTES_MAX; i++) begin
               if (3'(i) < delta_vlq.count) begin
                  push_run.bytes[i] = delta_vlq.bytes[i];
               end
            end
            pos = run_count_type'(delta_vlq.count);
            if (emit_status) begin
               push_run.bytes[pos] = status;
               pos = pos + 1'b1;
            end
            push_run.bytes[pos] = {1'b0, req_chan.data_first};
            pos = pos + 1'b1;
            if (two_data) begin
               push_run.bytes[pos] = {1'b0, req_chan.data_second};
               pos = pos + 1'b1;
            end
            push_run.count = pos;
         end
         KIND_META: begin
            for (int i = 0; i < VLQ_BYTES_MAX; i++) begin
               if (3'(i) < delta_vlq.count) begin
                  push_run.bytes[i] = delta_vlq.bytes[i];
               end
            end
            pos = run_count_type'(delta_vlq.count);
            push_run.bytes[pos] = META_PREFIX;
            pos = pos + 1'b1;
            push_run.bytes[pos] = req_chan.meta_kind;
            pos = pos + 1'b1;
            for (int i = 0; i < VLQ_BYTES_MAX; i++) begin
               if (3'(i) < length_vlq.count) begin
                  push_run.bytes[pos + run_count_type'(i)] = length_vlq.bytes[i];
               end
            end
            push_run.count = pos + run_count_type'(length_vlq.count);
         end
         KIND_PAYLOAD: begin
            push_run.bytes[0] = req_chan.payload_byte;
            push_run.count    = run_count_type'(1);
         end
         default: begin
            push_run.count = '0;
         end
      endcase
   end

   // The running status follows the accepted order, which is also the output order.
   always_comb begin
      running_status_in = running_status_ff;
      if (accept && req_chan.item_kind == KIND_CHANNEL) begin
         running_status_in = status;
      end else if (accept && req_chan.item_kind == KIND_META) begin
         running_status_in = RS_CLEARED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= RS_CLEARED;
      end else begin
         running_status_ff <= running_status_in;
      end
   end

endmodule

@@ rtl/mte_queue.sv @@
module mte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mte_pkg::run_type push_run,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output mte_pkg::run_type head_run
);
   import mte_pkg::*;

   run_type                     entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_in;
   logic [QUEUE_FILL_WIDTH-1:0] fill_ff;
   logic [QUEUE_FILL_WIDTH-1:0] fill_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (fill_ff == QUEUE_FILL_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_run   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

@@ rtl/mte_back.sv @@
module mte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  mte_pkg::run_type head_run,
   output logic             pop,
   mte_rsp_if.source        rsp_chan
);
   import mte_pkg::*;

   run_count_type index_ff;
   run_count_type index_in;
   logic          valid_ff;
   logic          valid_in;
   logic [7:0]    byte_ff;
   logic [7:0]    byte_in;
   logic          last_ff;
   logic          last_in;
   logic          load;
   logic          final_byte;

   assign load       = head_valid && (!valid_ff || rsp_chan.ready);
   assign final_byte = (index_ff == (head_run.count - 1'b1));
   assign pop        = load && final_byte;

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_run.bytes[index_ff];
         last_in  = final_byte;
         index_in = final_byte ? '0 : index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.last     = last_ff;

endmodule

@@ rtl/mte_checker.sv @@
module mte_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_item_kind,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);
   import mte_pkg::*;

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       run_in;
   logic       run_out;

   assign run_in  = req_valid && req_ready && (req_item_kind == KIND_CHANNEL ||
                                               req_item_kind == KIND_META ||
                                               req_item_kind == KIND_PAYLOAD);
   assign run_out = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      pending_in = pending_ff;
      if (run_in && !run_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (run_out && !run_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled byte must be held until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Every run end belongs to an item that was taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      run_out |-> pending_ff != '0)
      else $error("run ended with no item outstanding");

   // Two queued runs plus the one in the output register.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more runs outstanding than the block can hold");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_item_kind (req_chan.item_kind),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_last      (rsp_chan.last)
);
